[src/rotating_beacon_crossfade_unit_assert.svh]
// Assertion macros shared by the rotating beacon crossfade RTL.
// The macros expect clock aclk and active-low reset aresetn in the including scope.
`ifndef ROTATING_BEACON_CROSSFADE_UNIT_ASSERT_SVH
`define ROTATING_BEACON_CROSSFADE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rbcf_pkg.sv]
// Shared widths, register indexes and controller/datapath structs for the
// rotating beacon crossfade unit. No dependencies.
package rbcf_pkg;

    localparam int LED_COUNT_DEF = 8;

    localparam int COLOR_W  = 8;
    localparam int PERIOD_W = 30;
    localparam int TICKS_W  = 16;
    localparam int POS_W    = 8;
    localparam int DIVD_W   = PERIOD_W + 1;
    localparam int PROD_W   = PERIOD_W + POS_W;
    localparam int SQ_W     = 2 * PERIOD_W;
    localparam int FADE_STEPS = COLOR_W + 1;
    localparam int NUM_W    = SQ_W + FADE_STEPS + 1;
    localparam int CNT_W    = $clog2(DIVD_W);
    localparam int OUT_W    = 8 * COLOR_W;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_RED    = 2'd0;
    localparam logic [1:0] REG_GREEN  = 2'd1;
    localparam logic [1:0] REG_BLUE   = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef struct packed {
        logic accept;
        logic phase_load;
        logic div_step;
        logic mul;
        logic pos_load;
        logic sq;
        logic fade_load;
        logic fade_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic period_ok;
        logic out_free;
    } status_t;

endpackage

[src/rotating_beacon_crossfade_unit.sv]
// Rotating beacon crossfade: top level with the APB register file, the
// controller and the datapath. Depends on rbcf_pkg, rbcf_ctrl and rbcf_dp.
//
// Usage. Each input beat on the s_ channel either restarts the rotation at
// LED 0 (s_tuser high) or advances the phase by s_tdata ticks. Every input
// beat yields exactly one result beat on the m_ channel: the outgoing and
// incoming LED indexes and their red, green and blue levels, with m_tuser
// high when the rotation period is at least LED_COUNT. With a shorter period
// the result flags invalid and carries zeros, and the phase holds unless a
// restart clears it. An item with a valid period passes from acceptance to
// the result register through the 31-step restoring divider that reduces
// the phase and the 8-step division that splits it into position and
// fraction, followed by 9 steps of the fade division run on three color
// lanes at once. An item seen with an invalid period goes from acceptance
// straight to the output state and enters the result register once that is
// free. One item is processed at a time; the next beat waits until it is done.
// The result register decouples the sides: a new beat is accepted while a
// finished result still waits, and that item stalls at its end until the
// receiver takes the older result. Reset clears the phase, the registers,
// the controller state and the result valid flag. Registers are to be
// written over APB only while the block is idle; the block does not enforce it.
module rotating_beacon_crossfade_unit #(
    parameter int LED_COUNT = rbcf_pkg::LED_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [15:0] ticks_passed
    input  logic [15:0]                 s_tdata,
    // [0] restart
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] lit_position, [15:8] next_position, [23:16] outgoing_red,
    // [31:24] outgoing_green, [39:32] outgoing_blue, [47:40] incoming_red,
    // [55:48] incoming_green, [63:56] incoming_blue
    output logic [63:0]                 m_tdata,
    // [0] valid_res
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbcf_pkg::APB_AW-1:0] paddr,
    input  logic [rbcf_pkg::APB_DW-1:0] pwdata,
    output logic [rbcf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import rbcf_pkg::*;

    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    cmd_t                cmd;
    status_t             status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    // Register file: one 32-bit word per register, unused upper bits read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
            period_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RED:    red_reg    <= pwdata[COLOR_W-1:0];
                REG_GREEN:  green_reg  <= pwdata[COLOR_W-1:0];
                REG_BLUE:   blue_reg   <= pwdata[COLOR_W-1:0];
                REG_PERIOD: period_reg <= pwdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RED:    prdata = {{(APB_DW-COLOR_W){1'b0}}, red_reg};
            REG_GREEN:  prdata = {{(APB_DW-COLOR_W){1'b0}}, green_reg};
            REG_BLUE:   prdata = {{(APB_DW-COLOR_W){1'b0}}, blue_reg};
            REG_PERIOD: prdata = {{(APB_DW-PERIOD_W){1'b0}}, period_reg};
            default:    prdata = '0;
        endcase
    end

    // The controller sequences one item at a time through the datapath.
    rbcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbcf_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .restart         (s_tuser),
        .ticks_passed    (s_tdata[TICKS_W-1:0]),
        .color_red       (red_reg),
        .color_green     (green_reg),
        .color_blue      (blue_reg),
        .period_ticks    (period_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

[src/rbcf_div.sv]
// Shared radix-2 restoring divider for the phase and position reductions.
// Depends on rbcf_pkg.
module rbcf_div (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          step,
    input  logic [rbcf_pkg::PERIOD_W-1:0] rem_init,
    input  logic [rbcf_pkg::DIVD_W-1:0]   bits_init,
    input  logic [rbcf_pkg::PERIOD_W-1:0] divisor,
    output logic [rbcf_pkg::PERIOD_W-1:0] rem,
    output logic [rbcf_pkg::POS_W-1:0]    quo
);
    import rbcf_pkg::*;

    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0]   bits_reg, bits_next;
    logic [POS_W-1:0]    quo_reg, quo_next;
    logic [DIVD_W-1:0]   cand;
    logic [DIVD_W-1:0]   diff;
    logic                ge;

    // The partial remainder stays below the divisor, so one compare per step.
    assign cand = {rem_reg, bits_reg[DIVD_W-1]};
    assign diff = cand - {1'b0, divisor};
    assign ge   = cand >= {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        if (load) begin
            rem_next  = rem_init;
            bits_next = bits_init;
            quo_next  = '0;
        end else if (step) begin
            rem_next  = ge ? diff[PERIOD_W-1:0] : cand[PERIOD_W-1:0];
            bits_next = {bits_reg[DIVD_W-2:0], 1'b0};
            quo_next  = {quo_reg[POS_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
    end

    assign rem = rem_reg;
    assign quo = quo_reg;

endmodule

[src/rbcf_fade.sv]
// One color lane of the crossfade: rounds color * (f/P)^2 by restoring division.
// Depends on rbcf_pkg.
module rbcf_fade (
    input  logic                         aclk,
    input  logic                         load,
    input  logic                         step,
    input  logic [rbcf_pkg::COLOR_W-1:0] color,
    input  logic [rbcf_pkg::SQ_W-1:0]    sq_f,
    input  logic [rbcf_pkg::SQ_W-1:0]    sq_p,
    output logic [rbcf_pkg::COLOR_W-1:0] level
);
    import rbcf_pkg::*;

    logic [NUM_W-1:0]      num_reg, num_next;
    logic [NUM_W-1:0]      den_reg, den_next;
    logic [FADE_STEPS-1:0] k_reg, k_next;
    logic [NUM_W-1:0]      color2_ext;
    logic [NUM_W-1:0]      sq_f_ext;
    logic [NUM_W-1:0]      sq_p_ext;
    logic                  ge;

    // Numerator 2*c*f^2 + P^2 over denominator 2*P^2 gives the half-up rounding.
    assign color2_ext = {{(NUM_W-COLOR_W-1){1'b0}}, color, 1'b0};
    assign sq_f_ext   = {{(NUM_W-SQ_W){1'b0}}, sq_f};
    assign sq_p_ext   = {{(NUM_W-SQ_W){1'b0}}, sq_p};
    assign ge         = num_reg >= den_reg;

    always_comb begin
        num_next = num_reg;
        den_next = den_reg;
        k_next   = k_reg;
        if (load) begin
            num_next = color2_ext * sq_f_ext + sq_p_ext;
            den_next = NUM_W'({sq_p, {FADE_STEPS{1'b0}}});
            k_next   = '0;
        end else if (step) begin
            num_next = ge ? num_reg - den_reg : num_reg;
            den_next = {1'b0, den_reg[NUM_W-1:1]};
            k_next   = {k_reg[FADE_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        k_reg   <= k_next;
    end

    assign level = (k_reg > {1'b0, color}) ? color : k_reg[COLOR_W-1:0];

endmodule

[src/rbcf_ctrl.sv]
// Sequencing state machine of the crossfade unit; drives datapath commands.
// Depends on rbcf_pkg.
module rbcf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rbcf_pkg::status_t status,
    output rbcf_pkg::cmd_t    cmd
);
    import rbcf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV1  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_POSLD = 4'd3;
    localparam logic [3:0] ST_DIV2  = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_FLOAD = 4'd6;
    localparam logic [3:0] ST_FADE  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [CNT_W-1:0] PHASE_LAST = CNT_W'(DIVD_W - 1);
    localparam logic [CNT_W-1:0] POS_LAST   = CNT_W'(POS_W - 1);
    localparam logic [CNT_W-1:0] FADE_LAST  = CNT_W'(FADE_STEPS - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cnt_done;

    assign cnt_done = cnt_reg == '0;
    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.period_ok) begin
                        cmd.phase_load = 1'b1;
                        cnt_next       = PHASE_LAST;
                        state_next     = ST_DIV1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV1: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_POSLD;
            end
            ST_POSLD: begin
                cmd.pos_load = 1'b1;
                cnt_next     = POS_LAST;
                state_next   = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_done) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_FLOAD;
            end
            ST_FLOAD: begin
                cmd.fade_load = 1'b1;
                cnt_next      = FADE_LAST;
                state_next    = ST_FADE;
            end
            ST_FADE: begin
                cmd.fade_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[src/rbcf_dp.sv]
// Datapath of the crossfade unit: phase register, divider, squares, fade lanes
// and the result register. Depends on rbcf_pkg, rbcf_div, rbcf_fade and the macro header.
module rbcf_dp #(
    parameter int LED_COUNT = rbcf_pkg::LED_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rbcf_pkg::cmd_t                cmd,
    output rbcf_pkg::status_t             status,
    input  logic                          restart,
    input  logic [rbcf_pkg::TICKS_W-1:0]  ticks_passed,
    input  logic [rbcf_pkg::COLOR_W-1:0]  color_red,
    input  logic [rbcf_pkg::COLOR_W-1:0]  color_green,
    input  logic [rbcf_pkg::COLOR_W-1:0]  color_blue,
    input  logic [rbcf_pkg::PERIOD_W-1:0] period_ticks,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbcf_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tuser
);
    import rbcf_pkg::*;

    `include "rotating_beacon_crossfade_unit_assert.svh"

    logic [PERIOD_W-1:0] phase_reg;
    logic                item_ok_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SQ_W-1:0]     sq_f_reg;
    logic [SQ_W-1:0]     sq_p_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;

    logic                div_load;
    logic [PERIOD_W-1:0] div_rem_init;
    logic [DIVD_W-1:0]   div_bits_init;
    logic [PERIOD_W-1:0] div_rem;
    logic [POS_W-1:0]    div_quo;
    logic [DIVD_W-1:0]   phase_sum;
    logic [PROD_W-1:0]   rem_ext;
    logic [SQ_W-1:0]     f_ext;
    logic [SQ_W-1:0]     p_ext;
    logic [POS_W-1:0]    next_pos;
    logic [COLOR_W-1:0]  in_red;
    logic [COLOR_W-1:0]  in_green;
    logic [COLOR_W-1:0]  in_blue;

    assign status.period_ok = period_ticks >= PERIOD_W'(LED_COUNT);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // (phase + ticks) mod P equals ((phase mod P) + ticks) mod P, so one
    // division also folds in a phase left over from an older period.
    assign phase_sum = restart ? '0 : ({1'b0, phase_reg} + DIVD_W'(ticks_passed));

    // The position quotient is below 2^POS_W, so the top of phase*N already sits
    // below the divisor and only POS_W steps are needed.
    assign div_load      = cmd.phase_load || cmd.pos_load;
    assign div_rem_init  = cmd.pos_load ? prod_reg[PROD_W-1:POS_W] : '0;
    assign div_bits_init = cmd.pos_load ? {prod_reg[POS_W-1:0], {(DIVD_W-POS_W){1'b0}}}
                                        : phase_sum;

    rbcf_div u_div (
        .aclk      (aclk),
        .load      (div_load),
        .step      (cmd.div_step),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .divisor   (period_ticks),
        .rem       (div_rem),
        .quo       (div_quo)
    );

    assign rem_ext = {{(PROD_W-PERIOD_W){1'b0}}, div_rem};
    assign f_ext   = {{(SQ_W-PERIOD_W){1'b0}}, div_rem};
    assign p_ext   = {{(SQ_W-PERIOD_W){1'b0}}, period_ticks};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.accept && restart && !status.period_ok) begin
            phase_reg <= '0;
        end else if (cmd.mul) begin
            phase_reg <= div_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_ok_reg <= status.period_ok;
        end
        if (cmd.mul) begin
            prod_reg <= rem_ext * PROD_W'(LED_COUNT);
        end
        if (cmd.sq) begin
            sq_f_reg <= f_ext * f_ext;
            sq_p_reg <= p_ext * p_ext;
            pos_reg  <= div_quo;
        end
    end

    rbcf_fade u_fade_red (
        .aclk  (aclk),
        .load  (cmd.fade_load),
        .step  (cmd.fade_step),
        .color (color_red),
        .sq_f  (sq_f_reg),
        .sq_p  (sq_p_reg),
        .level (in_red)
    );

    rbcf_fade u_fade_green (
        .aclk  (aclk),
        .load  (cmd.fade_load),
        .step  (cmd.fade_step),
        .color (color_green),
        .sq_f  (sq_f_reg),
        .sq_p  (sq_p_reg),
        .level (in_green)
    );

    rbcf_fade u_fade_blue (
        .aclk  (aclk),
        .load  (cmd.fade_load),
        .step  (cmd.fade_step),
        .color (color_blue),
        .sq_f  (sq_f_reg),
        .sq_p  (sq_p_reg),
        .level (in_blue)
    );

    assign next_pos = (pos_reg == POS_W'(LED_COUNT - 1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= item_ok_reg;
            if (item_ok_reg) begin
                m_tdata_reg <= {in_blue, in_green, in_red,
                                color_blue - in_blue, color_green - in_green,
                                color_red - in_red, next_pos, pos_reg};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RBCF_ASSERT_SAME(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0,
        "invalid result carries nonzero data")
    `RBCF_ASSERT_NEXT(a_phase_in_range, cmd.mul, phase_reg < $past(period_ticks),
        "phase not reduced below the period")
    `RBCF_ASSERT_NEXT(a_out_shown, cmd.out_load, m_tvalid,
        "loaded result not presented")
    `RBCF_ASSERT_SAME(a_no_overwrite, cmd.out_load, status.out_free,
        "result register overwritten while still held")

endmodule

[tb/beacon_checker.sv]
`timescale 1ns / 1ps
// Checker for the rotating beacon crossfade unit: it tracks the register writes on APB,
// predicts one result beat per accepted input beat and compares the m_ channel against it.
// Depends on rbcf_pkg for the register indexes and the APB widths.
module beacon_checker #(
    parameter int LED_COUNT = rbcf_pkg::LED_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [15:0]                 s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [63:0]                 m_tdata,
    input  logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbcf_pkg::APB_AW-1:0] paddr,
    input  logic [rbcf_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending_count
);
    import rbcf_pkg::*;

    localparam int FIELD_COUNT = 9;
    localparam int REPORT_LIMIT = 10;

    // A frame is {valid_res, m_tdata} so that it lines up with the port packing.
    logic [7:0]  color_r, color_g, color_b;
    logic [29:0] period;
    logic [29:0] beacon_phase;
    logic [64:0] queued_frames[$];

    string field_name[FIELD_COUNT] = '{"lit_position", "next_position", "outgoing_red",
        "outgoing_green", "outgoing_blue", "incoming_red", "incoming_green",
        "incoming_blue", "valid_res"};

    // Incoming level: floor(c * f^2 / p^2 + 1/2), done exactly in wide integers.
    function automatic logic [7:0] incoming_level(input logic [7:0] level,
                                                  input logic [29:0] frac,
                                                  input logic [29:0] per);
        logic [127:0] lw, fw, pw, q;
        lw = level;
        fw = frac;
        pw = per;
        q = (((lw * fw * fw) << 1) + pw * pw) / ((pw * pw) << 1);
        return (q > lw) ? level : q[7:0];
    endfunction

    // Advances the phase for one input beat and returns the frame it produces.
    function automatic logic [64:0] next_beacon_frame(input logic restart,
                                                      input logic [15:0] ticks);
        logic [63:0] per, spread, pos, frac, nxt;
        logic [7:0]  in_r, in_g, in_b;
        per = period;
        if (restart) begin
            beacon_phase = '0;
        end else if (per >= LED_COUNT) begin
            beacon_phase = ((beacon_phase % per) + ticks) % per;
        end
        if (per < LED_COUNT) begin
            return '0;
        end
        spread = (beacon_phase % per) * LED_COUNT;
        pos = spread / per;
        frac = spread % per;
        nxt = (pos + 1) % LED_COUNT;
        in_r = incoming_level(color_r, frac[29:0], period);
        in_g = incoming_level(color_g, frac[29:0], period);
        in_b = incoming_level(color_b, frac[29:0], period);
        return {1'b1, in_b, in_g, in_r, 8'(color_b - in_b), 8'(color_g - in_g),
                8'(color_r - in_r), nxt[7:0], pos[7:0]};
    endfunction

    function automatic logic [7:0] field_of(input logic [64:0] frame, input int idx);
        return (idx == FIELD_COUNT - 1) ? {7'd0, frame[64]} : frame[8*idx +: 8];
    endfunction

    always @(posedge aclk) begin
        logic [64:0] want, got;
        if (!aresetn) begin
            color_r = '0;
            color_g = '0;
            color_b = '0;
            period = '0;
            beacon_phase = '0;
            queued_frames.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_RED:    color_r = pwdata[7:0];
                    REG_GREEN:  color_g = pwdata[7:0];
                    REG_BLUE:   color_b = pwdata[7:0];
                    REG_PERIOD: period = pwdata[29:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                queued_frames.push_back(next_beacon_frame(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (queued_frames.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result beat %h with no input waiting", $realtime, got);
                    end
                end else begin
                    want = queued_frames.pop_front();
                    for (int i = 0; i < FIELD_COUNT; i++) begin
                        if (field_of(want, i) !== field_of(got, i)) begin
                            fail_count++;
                            if (fail_count <= REPORT_LIMIT) begin
                                $display("%0t: %s expected %0d, got %0d", $realtime,
                                         field_name[i], field_of(want, i), field_of(got, i));
                            end
                        end
                    end
                end
            end
        end
        pending_count = queued_frames.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the rotating beacon crossfade testbench: clock, reset, stimulus and verdict.
// Depends on rbcf_pkg, the block rotating_beacon_crossfade_unit and beacon_checker.
module testbench;
    import rbcf_pkg::*;

    localparam int LEDS = LED_COUNT_DEF;
    localparam logic [29:0] PERIOD_MAX = 30'h3FFF_FFFF;
    localparam int SEGMENTS = 12;
    localparam int BEATS_PER_SEGMENT = 108;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;
    logic              m_tuser;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_count;

    // Percentages of cycles in which the sender and the receiver hold off.
    int tx_idle_pct = 31;
    int rx_idle_pct = 54;
    int rx_hold = 0;

    always #4 aclk = ~aclk;

    rotating_beacon_crossfade_unit #(
        .LED_COUNT(LEDS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] ticks_passed
        .s_tuser  (s_tuser),   // [0] restart
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // lit, next, outgoing r/g/b, incoming r/g/b, bytes upward
        .m_tuser  (m_tuser),   // [0] valid_res
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    beacon_checker #(
        .LED_COUNT(LEDS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // The receiver mostly drops tready for single cycles, but now and then holds it
    // low for longer than one item takes, so that a finished item has to wait at the
    // end of its work while the older result is still in the output register.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
            rx_hold = ($urandom_range(399) == 0) ? $urandom_range(40, 150) : 0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every task starts and ends at a falling edge, so that inputs only change there.
    // A beat that follows another keeps tvalid high; a gap lowers it first, so tvalid
    // is never lowered and raised within the same step.
    task automatic send_beat(input logic restart, input logic [15:0] ticks);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = ($urandom_range(19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= ticks;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Holds the sender off until every result beat owed so far has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
    endtask

    // An idle cycle follows each transfer, so the bus signals are driven once per step.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    // Registers only change once the block has gone idle; every item gives one result,
    // so an empty checker queue means nothing is in flight.
    task automatic set_beacon(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [29:0] per);
        drain_results();
        write_reg(REG_RED, {24'd0, red});
        write_reg(REG_GREEN, {24'd0, green});
        write_reg(REG_BLUE, {24'd0, blue});
        write_reg(REG_PERIOD, {2'd0, per});
    endtask

    function automatic logic [7:0] pick_color();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // The first segments pin the period to its smallest valid value, its largest value
    // and an invalid one; later segments mix small, medium and full-range periods.
    function automatic logic [29:0] pick_period(input int seg);
        if (seg == 0) return 30'(LEDS);
        if (seg == 1) return PERIOD_MAX;
        if (seg == 2) return 30'($urandom_range(0, LEDS - 1));
        case ($urandom_range(7))
            0:       return 30'(LEDS);
            1:       return 30'($urandom_range(0, LEDS - 1));
            2, 3:    return 30'($urandom_range(LEDS, 64));
            4, 5:    return 30'($urandom_range(65, 70000));
            default: return 30'($urandom);
        endcase
    endfunction

    // Random beats: mostly advances, with tick counts spread over the full field, the
    // small values that step slowly through a rotation and the two all-equal patterns.
    task automatic send_random_beat();
        logic        restart;
        logic [15:0] ticks;
        restart = ($urandom_range(24) == 0);
        case ($urandom_range(3))
            0:       ticks = 16'($urandom);
            1:       ticks = 16'($urandom_range(0, 300));
            2:       ticks = 16'($urandom_range(0, 15));
            default: ticks = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        if ($urandom_range(99) == 0) begin
            drain_results();
        end
        send_beat(restart, ticks);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Right after reset the period is zero, so every result is flagged invalid and
        // the phase only moves on a restart.
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'h0000);
        send_beat(1'b0, 16'hFFFF);

        // A nonzero period just below the LED count is still invalid.
        set_beacon(8'd255, 8'd0, 8'd128, 30'(LEDS - 1));
        send_beat(1'b0, 16'h1234);

        // With the smallest valid period each tick moves one LED; the walk wraps the ring.
        set_beacon(8'd255, 8'd255, 8'd255, 30'(LEDS));
        repeat (LEDS + 1) send_beat(1'b0, 16'h0001);

        // The largest period, then a much shorter one, leaves the phase beyond the
        // period, which has to be reduced before use.
        set_beacon(8'd255, 8'd255, 8'd255, PERIOD_MAX);
        repeat (4) send_beat(1'b0, 16'hFFFF);
        set_beacon(8'd255, 8'd0, 8'd1, 30'd1000);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b0, 16'hAAAA);
        send_beat(1'b0, 16'h5555);
        // A restart ignores its tick count; the last steps land close to a full fade.
        send_beat(1'b1, 16'h1234);
        send_beat(1'b0, 16'd999);
        send_beat(1'b0, 16'd124);

        // Random part in three idling regimes of four segments each.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_beacon(pick_color(), pick_color(), pick_color(), pick_period(seg));
            case (seg / 4)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 54;
                end
                1: begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (BEATS_PER_SEGMENT) send_random_beat();
        end

        // Wait for the last results, then a little longer to catch any stray beat.
        drain_results();
        repeat (64) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
